@@ src/dqe_pkg.sv @@
// ----------------------------------------------------------------------------
// dqe_pkg
// shared types and constants for the double-ended queue and its storage cells
// ----------------------------------------------------------------------------
package dqe_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // operation codes carried by an input beat (code 7 is a no-op)
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_PEEK_BACK  = 3'd4,
        OP_PEEK_FRONT = 3'd5,
        OP_CLEAR      = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // command broadcast along the cell row
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_UP   = 2'd1,
        CELL_SHIFT_DOWN = 2'd2,
        CELL_APPEND     = 2'd3
    } t_cell_op;

endpackage

@@ src/dqe_cell.sv @@
// ----------------------------------------------------------------------------
// dqe_cell
// one storage cell of the queue row: holds one element, takes from a neighbour
// ----------------------------------------------------------------------------
module dqe_cell
    import dqe_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 7
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [CNT_W-1:0]      i_held,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [DATA_WIDTH-1:0] i_lower_data,
    input  logic [DATA_WIDTH-1:0] i_upper_data,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tail_data
);

    // this cell is the first free slot when held equals its index,
    // and holds the back element when held is one past it
    localparam logic [CNT_W-1:0] SLOT = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] TAIL = CNT_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_SHIFT_UP:   n_data = i_lower_data;
            CELL_SHIFT_DOWN: n_data = i_upper_data;
            CELL_APPEND: begin
                if (i_held == SLOT) begin
                    n_data = i_push_data;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_tail_data = (i_held == TAIL) ? r_data : '0;

endmodule

@@ src/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque held in a row of shifting cells, one result beat per operation
// ----------------------------------------------------------------------------
//
// channel   dir  fields (tdata, lowest bit first)
// s_axis    in   op[3], push_value[DATA_WIDTH], zero pad to bytes
// m_axis    out  read_value[DATA_WIDTH], status[2], fill_count[CNT_W],
//                is_empty[1], zero pad to bytes
//
// one operation per clock: each accepted beat updates the cell row and the
// count in that cycle and loads its result into the output register in the
// same cycle. the front element always sits in cell 0, so front pushes and
// pops shift the whole row by one cell; back pushes fill the cell at the
// count's index, back pops and peeks read the cell below it. a stalled
// output beat blocks input only while it is not being taken. reset
// (synchronous, active low) empties the queue and the output register; cell
// contents are not cleared
module double_ended_queue
    import dqe_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((OP_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + STATUS_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // op, push_value
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    // read_value, status, fill_count, is_empty
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam int               PAD_W    = OUT_W - (DATA_WIDTH + STATUS_W + CNT_W + 1);

    // input beat fields
    t_op                   c_op;
    logic [DATA_WIDTH-1:0] c_push_data;
    logic                  c_accept;

    // queue state
    logic [CNT_W-1:0]      r_held;
    logic [CNT_W-1:0]      n_held;

    // output register
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;
    t_status               r_out_status;
    logic [CNT_W-1:0]      r_out_held;
    logic                  r_out_empty;

    // per operation decode
    t_cell_op              c_cell_op;
    t_status               c_status;
    logic [DATA_WIDTH-1:0] c_read_data;
    logic [DATA_WIDTH-1:0] c_back_data;
    logic                  c_full;
    logic                  c_empty;

    // cell row
    logic [DATA_WIDTH-1:0] w_cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tail_data [DEPTH];

    assign c_op        = t_op'(i_s_axis_tdata[OP_W-1:0]);
    assign c_push_data = i_s_axis_tdata[OP_W +: DATA_WIDTH];

    // output stage frees up in the same cycle its beat is taken
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign c_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign c_full  = (r_held == FULL_CNT);
    assign c_empty = (r_held == '0);

    // back element: only the tail cell drives a non-zero word
    always_comb begin
        c_back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            c_back_data = c_back_data | w_tail_data[i];
        end
    end

    // operation decode; refused and empty cases leave the row alone
    always_comb begin
        c_cell_op   = CELL_HOLD;
        c_status    = ST_OK;
        c_read_data = '0;
        n_held      = r_held;
        case (c_op)
            OP_PUSH_BACK: begin
                if (c_full) begin
                    c_status = ST_FULL;
                end else begin
                    c_cell_op = CELL_APPEND;
                    n_held    = r_held + ONE_CNT;
                end
            end
            OP_PUSH_FRONT: begin
                if (c_full) begin
                    c_status = ST_FULL;
                end else begin
                    c_cell_op = CELL_SHIFT_UP;
                    n_held    = r_held + ONE_CNT;
                end
            end
            OP_POP_BACK: begin
                if (c_empty) begin
                    c_status = ST_EMPTY;
                end else begin
                    c_read_data = c_back_data;
                    n_held      = r_held - ONE_CNT;
                end
            end
            OP_POP_FRONT: begin
                if (c_empty) begin
                    c_status = ST_EMPTY;
                end else begin
                    c_read_data = w_cell_data[0];
                    c_cell_op   = CELL_SHIFT_DOWN;
                    n_held      = r_held - ONE_CNT;
                end
            end
            OP_PEEK_BACK: begin
                if (c_empty) begin
                    c_status = ST_EMPTY;
                end else begin
                    c_read_data = c_back_data;
                end
            end
            OP_PEEK_FRONT: begin
                if (c_empty) begin
                    c_status = ST_EMPTY;
                end else begin
                    c_read_data = w_cell_data[0];
                end
            end
            OP_CLEAR: begin
                n_held = '0;
            end
            default: begin
                n_held = r_held;
            end
        endcase
        // nothing moves without an accepted beat
        if (!c_accept) begin
            c_cell_op = CELL_HOLD;
            n_held    = r_held;
        end
    end

    // row of cells: cell 0 is the front, lower neighbour of cell 0 is the
    // incoming element, the top cell refills from itself on a front pop
    genvar g;
    for (g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_lower;
        logic [DATA_WIDTH-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = c_push_data;
        end else begin : g_mid_lo
            assign w_lower = w_cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_upper = w_cell_data[g];
        end else begin : g_mid_hi
            assign w_upper = w_cell_data[g+1];
        end

        dqe_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (c_cell_op),
            .i_held       (r_held),
            .i_push_data  (c_push_data),
            .i_lower_data (w_lower),
            .i_upper_data (w_upper),
            .o_data       (w_cell_data[g]),
            .o_tail_data  (w_tail_data[g])
        );
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (c_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_out_data   <= c_read_data;
            r_out_status <= c_status;
            r_out_held   <= n_held;
            r_out_empty  <= (n_held == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_empty, r_out_held, r_out_status, r_out_data};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // count never passes the capacity
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= FULL_CNT)
        else $error("element count above capacity");

    // a refused push reports full and leaves the count alone
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && c_full && (c_op == OP_PUSH_BACK || c_op == OP_PUSH_FRONT))
        |=> (r_out_status == ST_FULL && $stable(r_held)))
        else $error("push on full queue not refused");

    // clear empties the queue and says so in its result
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && c_op == OP_CLEAR) |=> (r_held == '0 && r_out_empty))
        else $error("clear did not empty the queue");

endmodule
